@@ rtl/core/nls_pkg.sv @@
// Shared types, character codes and scan-step functions for the numeric literal scanner.
`default_nettype none
package nls_pkg;

	localparam int unsigned NLS_BUFFER_CHARS = 64;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEAD,
		PH_START,
		PH_MARK,
		PH_INT,
		PH_FRAC,
		PH_ESIGN,
		PH_EXP,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		RDX_DEC,
		RDX_HEX,
		RDX_BIN,
		RDX_OCT
	} radix_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_MALFORMED,
		ST_BAD_EXP,
		ST_TOO_LONG,
		ST_OVERFLOW
	} status_t;

	localparam logic [1:0] KIND_LITERAL   = 2'd0;
	localparam logic [1:0] KIND_AFTER_DOT = 2'd1;
	localparam logic [1:0] KIND_SIGNED    = 2'd2;
	localparam logic [1:0] KIND_SPARE     = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_O  = 8'h4F;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_O  = 8'h6F;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  mode;
		radix_t      radix;
		logic [15:0] pos;
		logic [63:0] acc;
		logic        ovf;
		logic        malf;
		logic        realf;
		logic        dseen;
		logic        pdig;
		logic        neg;
		logic        bad_exp;
		logic        tail_clean;
	} scan_t;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [1:0] cnt;
	} look_t;

	typedef struct packed {
		logic  valid;
		scan_t scan;
		look_t look;
	} stage_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic digit_in(logic [7:0] c, radix_t r);
		logic ok;
		begin
			unique case (r)
				RDX_HEX: ok = is_dec(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
					((c >= CH_UC_A) && (c <= CH_UC_F));
				RDX_BIN: ok = (c == CH_0) || (c == CH_1);
				RDX_OCT: ok = (c >= CH_0) && (c <= CH_7);
				default: ok = is_dec(c);
			endcase
			return ok;
		end
	endfunction

	function automatic logic [3:0] digit_val(logic [7:0] c);
		logic [7:0] v;
		begin
			if (is_dec(c))
				v = c - CH_0;
			else if (c >= CH_LC_A)
				v = c - CH_LC_A + 8'd10;
			else
				v = c - CH_UC_A + 8'd10;
			return v[3:0];
		end
	endfunction

	function automatic logic [15:0] take(logic [15:0] p);
		return (p == 16'hFFFF) ? p : p + 16'd1;
	endfunction

	function automatic scan_t scan_reset();
		scan_t s;
		begin
			s = '0;
			s.phase = PH_IDLE;
			s.radix = RDX_DEC;
			s.tail_clean = 1'b1;
			return s;
		end
	endfunction

	function automatic scan_t scan_start(logic [1:0] k);
		scan_t s;
		begin
			s = scan_reset();
			s.mode = (k == KIND_SPARE) ? KIND_LITERAL : k;
			s.phase = (s.mode == KIND_SIGNED) ? PH_LEAD : PH_START;
			return s;
		end
	endfunction

	// One byte judged with two bytes of lookahead; phases only move forward.
	function automatic scan_t judge(scan_t s_in, logic [7:0] c, logic [7:0] n1,
			logic [7:0] n2, logic real_byte);
		scan_t       s;
		logic        done;
		radix_t      rc;
		logic        sgn;
		logic [67:0] scaled;
		logic [67:0] wide;
		begin
			s = s_in;
			done = 1'b0;
			rc = RDX_DEC;
			sgn = 1'b0;
			scaled = '0;
			wide = '0;
			if (s.phase == PH_LEAD) begin
				if (real_byte && is_space(c)) begin
					done = 1'b1;
				end else begin
					s.phase = PH_START;
					if ((c == CH_PLUS) || (c == CH_MINUS)) begin
						s.neg = (c == CH_MINUS);
						done = 1'b1;
					end
				end
			end
			if (!done && (s.phase == PH_START)) begin
				if ((n1 == CH_LC_X) || (n1 == CH_UC_X))
					rc = RDX_HEX;
				else if ((n1 == CH_LC_B) || (n1 == CH_UC_B))
					rc = RDX_BIN;
				else if ((n1 == CH_LC_O) || (n1 == CH_UC_O))
					rc = RDX_OCT;
				if ((s.mode != KIND_AFTER_DOT) && (c == CH_0) && (rc != RDX_DEC)) begin
					s.radix = rc;
					s.pos = take(s.pos);
					s.phase = PH_MARK;
					done = 1'b1;
				end else begin
					s.phase = PH_INT;
					s.pdig = 1'b0;
				end
			end
			if (!done && ((s.phase == PH_MARK) || (s.phase == PH_ESIGN))) begin
				s.pos = take(s.pos);
				s.phase = (s.phase == PH_MARK) ? PH_INT : PH_EXP;
				s.pdig = 1'b0;
				done = 1'b1;
			end
			if (!done && ((s.phase == PH_INT) || (s.phase == PH_FRAC) ||
					(s.phase == PH_EXP))) begin
				rc = (s.phase == PH_INT) ? s.radix : RDX_DEC;
				done = 1'b1;
				if (c == CH_USCORE) begin
					if (!s.pdig || !digit_in(n1, rc))
						s.malf = 1'b1;
					s.pos = take(s.pos);
					s.pdig = 1'b0;
				end else if (digit_in(c, rc)) begin
					s.pos = take(s.pos);
					s.pdig = 1'b1;
					if (s.phase == PH_INT) begin
						unique case (rc)
							RDX_HEX: scaled = {s.acc, 4'b0000};
							RDX_BIN: scaled = {3'b000, s.acc, 1'b0};
							RDX_OCT: scaled = {1'b0, s.acc, 3'b000};
							default: scaled = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0};
						endcase
						wide = scaled + {64'd0, digit_val(c)};
						s.dseen = 1'b1;
						if (wide[67:64] != 4'd0)
							s.ovf = 1'b1;
						s.acc = wide[63:0];
					end
				end else if ((s.phase == PH_INT) &&
						((s.radix != RDX_DEC) || (s.mode == KIND_AFTER_DOT))) begin
					s.phase = PH_TAIL;
					done = 1'b0;
				end else if ((s.phase == PH_INT) && (c == CH_DOT) && is_dec(n1)) begin
					s.pos = take(s.pos);
					s.realf = 1'b1;
					s.phase = PH_FRAC;
					s.pdig = 1'b0;
				end else if ((s.phase != PH_EXP) && ((c == CH_LC_E) || (c == CH_UC_E))) begin
					sgn = (n1 == CH_PLUS) || (n1 == CH_MINUS);
					s.pos = take(s.pos);
					if (!is_dec(sgn ? n2 : n1)) begin
						s.bad_exp = 1'b1;
						s.phase = PH_TAIL;
					end else begin
						s.realf = 1'b1;
						s.phase = sgn ? PH_ESIGN : PH_EXP;
						s.pdig = 1'b0;
					end
				end else begin
					s.phase = PH_TAIL;
					done = 1'b0;
				end
			end
			if (!done && (s.phase == PH_TAIL)) begin
				if (real_byte && !is_space(c))
					s.tail_clean = 1'b0;
			end
			return s;
		end
	endfunction

	// Judge the oldest held byte of an ended text and drop it.
	function automatic stage_t drain_one(stage_t st);
		stage_t r;
		begin
			r = st;
			if (st.look.cnt != 2'd0) begin
				r.scan = judge(st.scan, st.look.b0,
					(st.look.cnt == 2'd2) ? st.look.b1 : CH_NUL, CH_NUL, 1'b1);
				r.look.b0 = st.look.b1;
				r.look.b1 = CH_NUL;
				r.look.cnt = st.look.cnt - 2'd1;
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/nls_scan.sv @@
// Input stage: text state, lookahead bytes and the per-word judge step.
`default_nettype none
module nls_scan import nls_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] character,
	input  wire logic       has_char,
	input  wire logic       first,
	input  wire logic       last,
	input  wire logic [1:0] kind,
	input  wire logic       down_free,
	output stage_t          stage_o
);

	scan_t state_q;
	look_t look_q;
	logic  valid_s1;
	scan_t scan_s1;
	look_t look_s1;

	scan_t sc;
	look_t lk;
	scan_t sc_keep;
	look_t lk_keep;
	logic  free;
	logic  accept;

	always_comb begin
		free = !valid_s1 || down_free;
		accept = in_valid && free;
		sc = state_q;
		lk = look_q;
		if (first) begin
			sc = scan_start(kind);
			lk = '0;
		end else if (state_q.phase == PH_IDLE) begin
			sc = scan_start(state_q.mode);
			lk = '0;
		end
		if (has_char) begin
			if (lk.cnt == 2'd2) begin
				sc = judge(sc, lk.b0, lk.b1, character, 1'b1);
				lk.b0 = lk.b1;
				lk.b1 = character;
			end else if (lk.cnt == 2'd1) begin
				lk.b1 = character;
				lk.cnt = 2'd2;
			end else begin
				lk.b0 = character;
				lk.cnt = 2'd1;
			end
		end
		sc_keep = sc;
		lk_keep = lk;
		if (last) begin
			sc_keep.phase = PH_IDLE;
			lk_keep.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scan_reset();
			look_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= sc_keep;
				look_q <= lk_keep;
			end
			if (free)
				valid_s1 <= accept && last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			scan_s1 <= sc;
			look_s1 <= lk;
		end
	end

	assign in_ready = free;

	always_comb begin
		stage_o.valid = valid_s1;
		stage_o.scan = scan_s1;
		stage_o.look = look_s1;
	end

endmodule
`default_nettype wire

@@ rtl/core/nls_drain.sv @@
// Two stages that judge the held lookahead bytes of an ended text.
`default_nettype none
module nls_drain import nls_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire stage_t stage_i,
	output logic        up_free,
	input  wire logic   down_free,
	output stage_t      stage_o
);

	logic   valid_s2;
	stage_t st_s2;
	logic   valid_s3;
	stage_t st_s3;
	logic   free_s2;
	logic   free_s3;
	stage_t next_s2;
	stage_t next_s3;

	always_comb begin
		free_s3 = !valid_s3 || down_free;
		free_s2 = !valid_s2 || free_s3;
		next_s2 = drain_one(stage_i);
		next_s3 = drain_one(st_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (free_s2)
				valid_s2 <= stage_i.valid;
			if (free_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && stage_i.valid)
			st_s2 <= next_s2;
		if (free_s3 && valid_s2)
			st_s3 <= next_s3;
	end

	assign up_free = free_s2;

	always_comb begin
		stage_o = st_s3;
		stage_o.valid = valid_s3;
	end

endmodule
`default_nettype wire

@@ rtl/core/nls_result.sv @@
// End-of-text judge, status and signed-read checks, and the result register.
`default_nettype none
module nls_result import nls_pkg::*; #(
	parameter int unsigned BUFFER_CHARS = NLS_BUFFER_CHARS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire stage_t      stage_i,
	output logic             up_free,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      literal_length,
	output logic [1:0]       radix_code,
	output logic             is_real,
	output logic [63:0]      magnitude,
	output logic             read_ok,
	output logic signed [63:0] signed_value
);

	logic        valid_s4;
	status_t     status_s4;
	logic [15:0] pos_s4;
	radix_t      radix_s4;
	logic        real_s4;
	logic [63:0] mag_s4;
	logic        rok_s4;
	logic        use_sval_s4;
	logic        neg_s4;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] length_q;
	logic [1:0]  radix_q;
	logic        real_q;
	logic [63:0] mag_q;
	logic        rok_q;
	logic [63:0] sval_q;

	scan_t       fin;
	status_t     st;
	logic        rl;
	logic [63:0] mg;
	logic        fits;
	logic        rok;
	logic        free_s4;
	logic        out_free;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		free_s4 = !valid_s4 || out_free;
		fin = judge(stage_i.scan, CH_NUL, CH_NUL, CH_NUL, 1'b0);
		rl = 1'b0;
		if (fin.bad_exp) begin
			st = ST_BAD_EXP;
		end else begin
			rl = fin.realf;
			if (fin.malf || !fin.dseen)
				st = ST_MALFORMED;
			else if (fin.pos >= 16'(BUFFER_CHARS))
				st = ST_TOO_LONG;
			else if (!fin.realf && fin.ovf)
				st = ST_OVERFLOW;
			else
				st = ST_OK;
		end
		mg = ((st == ST_OK) && !fin.realf) ? fin.acc : 64'd0;
		// int64 range: up to 2^63 when negative, below 2^63 otherwise
		fits = !mg[63] || (fin.neg && (mg[62:0] == 63'd0));
		rok = (fin.mode == KIND_SIGNED) && (st == ST_OK) && fin.tail_clean &&
			(fin.realf || fits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s4)
				valid_s4 <= stage_i.valid;
			if (out_free)
				out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s4 && stage_i.valid) begin
			status_s4 <= st;
			pos_s4 <= fin.pos;
			radix_s4 <= fin.radix;
			real_s4 <= rl;
			mag_s4 <= mg;
			rok_s4 <= rok;
			use_sval_s4 <= rok && !fin.realf;
			neg_s4 <= fin.neg;
		end
		if (out_free && valid_s4) begin
			status_q <= status_s4;
			length_q <= pos_s4;
			radix_q <= radix_s4;
			real_q <= real_s4;
			mag_q <= mag_s4;
			rok_q <= rok_s4;
			if (!use_sval_s4)
				sval_q <= 64'd0;
			else if (neg_s4)
				sval_q <= ~mag_s4 + 64'd1;
			else
				sval_q <= mag_s4;
		end
	end

	assign up_free = free_s4;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign literal_length = length_q;
	assign radix_code = radix_q;
	assign is_real = real_q;
	assign magnitude = mag_q;
	assign read_ok = rok_q;
	assign signed_value = sval_q;

endmodule
`default_nettype wire

@@ rtl/core/numeric_literal_scanner_core.sv @@
// Numeric literal scanner: at most one text byte per word in, one result word per text out.
// Throughput: one input word per clock while the result side keeps up; in_ready drops
// only when every stage holds a result word.
// Path: after the last word is taken, the result word passes in order through the input judge,
// two lookahead drain stages, the end-of-text check and the result register.
// Reset: arst_n clears the scan state to idle, empties the lookahead and all stage valids.
`default_nettype none
module numeric_literal_scanner_core import nls_pkg::*; #(
	parameter int unsigned BUFFER_CHARS = NLS_BUFFER_CHARS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    character,
	input  wire logic          has_char,
	input  wire logic          first,
	input  wire logic          last,
	input  wire logic [1:0]    kind,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         status,
	output logic [15:0]        literal_length,
	output logic [1:0]         radix_code,
	output logic               is_real,
	output logic [63:0]        magnitude,
	output logic               read_ok,
	output logic signed [63:0] signed_value
);

	stage_t scan_st;
	stage_t drain_st;
	logic   drain_free;
	logic   result_free;

	nls_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.has_char  (has_char),
		.first     (first),
		.last      (last),
		.kind      (kind),
		.down_free (drain_free),
		.stage_o   (scan_st)
	);

	nls_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_i   (scan_st),
		.up_free   (drain_free),
		.down_free (result_free),
		.stage_o   (drain_st)
	);

	nls_result #(
		.BUFFER_CHARS (BUFFER_CHARS)
	) u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.stage_i        (drain_st),
		.up_free        (result_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.literal_length (literal_length),
		.radix_code     (radix_code),
		.is_real        (is_real),
		.magnitude      (magnitude),
		.read_ok        (read_ok),
		.signed_value   (signed_value)
	);

endmodule
`default_nettype wire
